// ----- sv/whp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the WAV header parser.
// No dependencies; every other file but whp_fifo refers to this package by scoped names.
package whp_pkg;

  // Tags as they appear once four little-endian bytes have been shifted in.
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam int unsigned FmtFieldBytes = 16;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CTAG  = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FTYPE = 4'd5,
    PH_FCHAN = 4'd6,
    PH_FRATE = 4'd7,
    PH_FSKIP = 4'd8,
    PH_FBITS = 4'd9,
    PH_SKIP  = 4'd10
  } whp_phase_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_TAG     = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_TRUNCATED   = 2'd3
  } whp_status_e;

  typedef enum logic [1:0] {
    SMP_INT8    = 2'd0,
    SMP_INT16   = 2'd1,
    SMP_INT32   = 2'd2,
    SMP_FLOAT32 = 2'd3
  } whp_sample_e;

  // One classified byte, as handed from the front end to the parser.
  typedef struct packed {
    logic [31:0] word;      // last four bytes, newest in the top byte
    logic [31:0] pos_next;  // file position just past this byte
    logic        sof;
    logic        eof;
    logic        is_riff;
    logic        is_wave;
    logic        is_fmt;
    logic        is_data;
    logic        half_is8;  // upper half-word compares
    logic        half_is16;
    logic        half_is32;
    logic        half_is1;
    logic        half_is3;
  } whp_entry_t;

  localparam int unsigned EntryWidth = $bits(whp_entry_t);

  // Status of the parser, for checking at the top level.
  typedef struct packed {
    logic pop;
    logic emit;
    logic finished;
  } whp_back_st_t;

endpackage

// ----- sv/whp_fifo.sv -----
`timescale 1ns / 1ps
// Small register queue between the front end and the parser of the WAV header parser.
// Uses no package; width and depth come from parameters.
module whp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             pop_valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/whp_front.sv -----
`timescale 1ns / 1ps
// Front end of the WAV header parser: assembles the byte window and file position
// and classifies each byte against the known tags. Depends on whp_pkg.
module whp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                sof_i,
  input  logic                eof_i,
  output whp_pkg::whp_entry_t entry_o
);

  logic [31:0] word_q, word_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] word_base, pos_base;
  logic [15:0] half;

  // A start of file restarts both the window and the position from zero.
  assign word_base = sof_i ? 32'd0 : word_q;
  assign pos_base  = sof_i ? 32'd0 : pos_q;
  assign word_d    = {byte_i, word_base[31:8]};
  assign pos_d     = pos_base + 32'd1;
  assign half      = word_d[31:16];

  always_comb begin
    entry_o           = '0;
    entry_o.word      = word_d;
    entry_o.pos_next  = pos_d;
    entry_o.sof       = sof_i;
    entry_o.eof       = eof_i;
    entry_o.is_riff   = (word_d == whp_pkg::TagRiff);
    entry_o.is_wave   = (word_d == whp_pkg::TagWave);
    entry_o.is_fmt    = (word_d == whp_pkg::TagFmt);
    entry_o.is_data   = (word_d == whp_pkg::TagData);
    entry_o.half_is8  = (half == 16'd8);
    entry_o.half_is16 = (half == 16'd16);
    entry_o.half_is32 = (half == 16'd32);
    entry_o.half_is1  = (half == 16'd1);
    entry_o.half_is3  = (half == 16'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      pos_q  <= '0;
    end else if (accept_i) begin
      word_q <= word_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// ----- sv/whp_back.sv -----
`timescale 1ns / 1ps
// Parser back end of the WAV header parser: chunk walking state machine and result register.
// Depends on whp_pkg; takes classified bytes from the queue.
module whp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  whp_pkg::whp_entry_t   in_entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output whp_pkg::whp_status_e  out_status_o,
  output logic [31:0]           out_rate_o,
  output logic [7:0]            out_chan_o,
  output logic [1:0]            out_type_o,
  output logic [31:0]           out_offs_o,
  output logic [31:0]           out_len_o,
  output whp_pkg::whp_back_st_t st_o
);

  whp_pkg::whp_phase_e phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        tag_fmt_q, tag_fmt_d, tag_data_q, tag_data_d;
  logic [31:0] left_q, left_d;
  logic        seen_fmt_q, seen_fmt_d, seen_data_q, seen_data_d;
  logic        code1_q, code1_d, code3_q, code3_d;
  logic [31:0] rate_q, rate_d;
  logic [7:0]  chan_q, chan_d;
  whp_pkg::whp_sample_e stype_q, stype_d;
  logic [31:0] offs_q, offs_d, len_q, len_d;
  logic        fin_q, fin_d;

  logic        ov_q;
  whp_pkg::whp_status_e ostat_q;
  logic [31:0] orate_q, ooffs_q, olen_q;
  logic [7:0]  ochan_q;
  logic [1:0]  otype_q;

  logic        pop, emit;
  whp_pkg::whp_status_e est;
  logic [2:0]  need;
  logic [31:0] w;

  assign pop = in_valid_i && (!ov_q || out_ready_i);
  assign w   = in_entry_i.word;

  always_comb begin
    emit = 1'b0;
    est  = whp_pkg::ST_OK;
    need = 3'd2;
    // Start of file: continue from the reset state.
    if (in_entry_i.sof) begin
      phase_d     = whp_pkg::PH_RIFF;
      cnt_d       = '0;
      tag_fmt_d   = 1'b0;
      tag_data_d  = 1'b0;
      left_d      = '0;
      seen_fmt_d  = 1'b0;
      seen_data_d = 1'b0;
      code1_d     = 1'b0;
      code3_d     = 1'b0;
      rate_d      = '0;
      chan_d      = '0;
      stype_d     = whp_pkg::SMP_INT8;
      offs_d      = '0;
      len_d       = '0;
      fin_d       = 1'b0;
    end else begin
      phase_d     = phase_q;
      cnt_d       = cnt_q;
      tag_fmt_d   = tag_fmt_q;
      tag_data_d  = tag_data_q;
      left_d      = left_q;
      seen_fmt_d  = seen_fmt_q;
      seen_data_d = seen_data_q;
      code1_d     = code1_q;
      code3_d     = code3_q;
      rate_d      = rate_q;
      chan_d      = chan_q;
      stype_d     = stype_q;
      offs_d      = offs_q;
      len_d       = len_q;
      fin_d       = fin_q;
    end

    if (!fin_d) begin
      cnt_d = cnt_d + 3'd1;
      case (phase_d)
        whp_pkg::PH_RIFF, whp_pkg::PH_RSIZE, whp_pkg::PH_WAVE,
        whp_pkg::PH_CTAG, whp_pkg::PH_CSIZE, whp_pkg::PH_FRATE: need = 3'd4;
        whp_pkg::PH_FSKIP: need = 3'd6;
        whp_pkg::PH_SKIP:  need = 3'd1;
        default:           need = 3'd2;
      endcase
      if (cnt_d >= need) begin
        cnt_d = '0;
        case (phase_d)
          whp_pkg::PH_RIFF: begin
            if (!in_entry_i.is_riff) begin
              emit = 1'b1;
              est  = whp_pkg::ST_BAD_TAG;
            end else begin
              phase_d = whp_pkg::PH_RSIZE;
            end
          end
          whp_pkg::PH_RSIZE: phase_d = whp_pkg::PH_WAVE;
          whp_pkg::PH_WAVE: begin
            if (!in_entry_i.is_wave) begin
              emit = 1'b1;
              est  = whp_pkg::ST_BAD_TAG;
            end else begin
              phase_d = whp_pkg::PH_CTAG;
            end
          end
          whp_pkg::PH_CTAG: begin
            tag_fmt_d  = in_entry_i.is_fmt;
            tag_data_d = in_entry_i.is_data;
            phase_d    = whp_pkg::PH_CSIZE;
          end
          whp_pkg::PH_CSIZE: begin
            if (tag_fmt_d) begin
              left_d  = (w > 32'(whp_pkg::FmtFieldBytes)) ?
                        w - 32'(whp_pkg::FmtFieldBytes) : 32'd0;
              phase_d = whp_pkg::PH_FTYPE;
            end else begin
              if (tag_data_d) begin
                offs_d      = in_entry_i.pos_next;
                len_d       = w;
                seen_data_d = 1'b1;
                if (seen_fmt_d) begin
                  emit = 1'b1;
                end
              end
              left_d  = w;
              phase_d = (w != 32'd0) ? whp_pkg::PH_SKIP : whp_pkg::PH_CTAG;
            end
          end
          whp_pkg::PH_FTYPE: begin
            code1_d = in_entry_i.half_is1;
            code3_d = in_entry_i.half_is3;
            phase_d = whp_pkg::PH_FCHAN;
          end
          whp_pkg::PH_FCHAN: begin
            chan_d  = w[23:16];
            phase_d = whp_pkg::PH_FRATE;
          end
          whp_pkg::PH_FRATE: begin
            rate_d  = w;
            phase_d = whp_pkg::PH_FSKIP;
          end
          whp_pkg::PH_FSKIP: phase_d = whp_pkg::PH_FBITS;
          whp_pkg::PH_FBITS: begin
            if (in_entry_i.half_is8 || in_entry_i.half_is16 ||
                (in_entry_i.half_is32 && (code1_d || code3_d))) begin
              if (in_entry_i.half_is8) begin
                stype_d = whp_pkg::SMP_INT8;
              end else if (in_entry_i.half_is16) begin
                stype_d = whp_pkg::SMP_INT16;
              end else if (code1_d) begin
                stype_d = whp_pkg::SMP_INT32;
              end else begin
                stype_d = whp_pkg::SMP_FLOAT32;
              end
              seen_fmt_d = 1'b1;
              if (seen_data_d) begin
                emit = 1'b1;
              end
              phase_d = (left_d != 32'd0) ? whp_pkg::PH_SKIP : whp_pkg::PH_CTAG;
            end else begin
              emit = 1'b1;
              est  = whp_pkg::ST_UNSUPPORTED;
            end
          end
          default: begin
            if (left_d != 32'd0) begin
              left_d = left_d - 32'd1;
            end
            if (left_d == 32'd0) begin
              phase_d = whp_pkg::PH_CTAG;
            end
          end
        endcase
      end
      if (!emit && in_entry_i.eof) begin
        emit = 1'b1;
        est  = whp_pkg::ST_TRUNCATED;
      end
      if (emit) begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= whp_pkg::PH_RIFF;
      cnt_q       <= '0;
      tag_fmt_q   <= 1'b0;
      tag_data_q  <= 1'b0;
      left_q      <= '0;
      seen_fmt_q  <= 1'b0;
      seen_data_q <= 1'b0;
      code1_q     <= 1'b0;
      code3_q     <= 1'b0;
      rate_q      <= '0;
      chan_q      <= '0;
      stype_q     <= whp_pkg::SMP_INT8;
      offs_q      <= '0;
      len_q       <= '0;
      fin_q       <= 1'b0;
    end else if (pop) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      tag_fmt_q   <= tag_fmt_d;
      tag_data_q  <= tag_data_d;
      left_q      <= left_d;
      seen_fmt_q  <= seen_fmt_d;
      seen_data_q <= seen_data_d;
      code1_q     <= code1_d;
      code3_q     <= code3_d;
      rate_q      <= rate_d;
      chan_q      <= chan_d;
      stype_q     <= stype_d;
      offs_q      <= offs_d;
      len_q       <= len_d;
      fin_q       <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (pop && emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Error results carry zeros in every field but the status.
  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      ostat_q <= est;
      if (est == whp_pkg::ST_OK) begin
        orate_q <= rate_d;
        ochan_q <= chan_d;
        otype_q <= stype_d;
        ooffs_q <= offs_d;
        olen_q  <= len_d;
      end else begin
        orate_q <= '0;
        ochan_q <= '0;
        otype_q <= '0;
        ooffs_q <= '0;
        olen_q  <= '0;
      end
    end
  end

  assign pop_o        = pop;
  assign out_valid_o  = ov_q;
  assign out_status_o = ostat_q;
  assign out_rate_o   = orate_q;
  assign out_chan_o   = ochan_q;
  assign out_type_o   = otype_q;
  assign out_offs_o   = ooffs_q;
  assign out_len_o    = olen_q;

  always_comb begin
    st_o          = '0;
    st_o.pop      = pop;
    st_o.emit     = emit;
    st_o.finished = fin_q;
  end

endmodule

// ----- sv/wav_header_parser.sv -----
`timescale 1ns / 1ps
// Top level of the WAV header parser: front end, queue and parser back end.
// Depends on whp_pkg, whp_front, whp_fifo and whp_back.

// The block reads a WAV file as a stream of bytes, one byte per request on the slave
// side, and takes one byte in every clock cycle while the queue has room. A front end
// keeps the last four bytes and the file position and compares them against the RIFF,
// WAVE, fmt and data tags; a short queue of FifoDepth entries hands these classified
// bytes to the parser, which walks the chunks and holds the fmt fields. The last byte
// of a result passes the queue, and the result the output register, before it is valid.
// While a result waits in the output register the parser holds, and the slave side
// keeps taking bytes until the queue is full. Raise tuser with
// the first byte of every file; it restarts the parse. Raise tlast with the last byte
// available: a file that ends before its result is complete gives a truncated status.
// After a result, bytes are dropped until the next start of file. When the status is
// not ok, every other field of the result is zero.
module wav_header_parser #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // byte_value [7:0]
  input  logic         s_axis_tuser_i,   // start_of_file [0]
  input  logic         s_axis_tlast_i,   // end_of_file
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // sample_rate [31:0], channels [39:32], sample_type [41:40], data_offset [73:42],
  // data_length [105:74], zero padding [111:106]
  output logic [111:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o    // status [1:0]
);

  whp_pkg::whp_entry_t   push_entry, pop_entry;
  logic [whp_pkg::EntryWidth-1:0] pop_bits;
  logic                  in_accept, q_ready, q_valid, q_pop;
  whp_pkg::whp_status_e  res_status;
  logic [31:0]           res_rate, res_offs, res_len;
  logic [7:0]            res_chan;
  logic [1:0]            res_type;
  whp_pkg::whp_back_st_t back_st;

  assign s_axis_tready_o = q_ready;
  assign in_accept       = s_axis_tvalid_i && q_ready;

  whp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata_i),
    .sof_i    (s_axis_tuser_i),
    .eof_i    (s_axis_tlast_i),
    .entry_o  (push_entry)
  );

  whp_fifo #(
    .Width (whp_pkg::EntryWidth),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_accept),
    .push_data_i  (push_entry),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_data_o   (pop_bits),
    .pop_valid_o  (q_valid)
  );

  assign pop_entry = whp_pkg::whp_entry_t'(pop_bits);

  whp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_entry_i   (pop_entry),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (res_status),
    .out_rate_o   (res_rate),
    .out_chan_o   (res_chan),
    .out_type_o   (res_type),
    .out_offs_o   (res_offs),
    .out_len_o    (res_len),
    .st_o         (back_st)
  );

  assign m_axis_tdata_o = {6'd0, res_len, res_offs, res_type, res_chan, res_rate};
  assign m_axis_tuser_o = res_status;

  // An error result never carries field data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res_status != whp_pkg::ST_OK)) |-> (m_axis_tdata_o == '0))
    else $error("error result with nonzero fields");

  // The parser only consumes entries that the queue holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.pop |-> q_valid)
    else $error("parser popped an empty queue");

  // A delivered result leaves the parser idle until the next start of file.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_st.pop && back_st.emit) |=> (back_st.finished && m_axis_tvalid_o))
    else $error("parser not finished after a result");

  // A result never appears without a byte having been parsed in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(back_st.pop && back_st.emit))
    else $error("result appeared without a parsed byte");

endmodule

// ----- verif/wav_header_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the WAV header parser: byte streams in, header results out.
// Depends on whp_pkg and the wav_header_parser RTL; nothing else is read or needed.
module wav_header_parser_tb;

  localparam int unsigned ByteTarget    = 1950;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned QuietFirst    = 600;
  localparam int unsigned QuietLast     = 1400;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned StallLimit    = 3000;

  typedef logic [7:0] byte_q_t[$];

  // One header result, in the order of the fields on the master side.
  typedef struct packed {
    whp_pkg::whp_status_e status;
    logic [31:0]          sample_rate;
    logic [7:0]           channels;
    whp_pkg::whp_sample_e sample_type;
    logic [31:0]          data_offset;
    logic [31:0]          data_length;
  } wav_info_t;

  // Tracks the parse of the byte stream and holds the header results still owed.
  class wav_result_scoreboard;
    whp_pkg::whp_phase_e  phase;
    logic [2:0]  byte_cnt;
    logic [31:0] shift;
    logic [31:0] tag;
    logic [31:0] left;
    logic [31:0] file_pos;
    bit          have_fmt;
    bit          have_data;
    logic [15:0] fmt_type;
    logic [31:0] rate;
    logic [7:0]  chans;
    whp_pkg::whp_sample_e smp;
    logic [31:0] offset;
    logic [31:0] length;
    bit          done;

    wav_info_t   expected_q[$];
    int unsigned mismatches;
    int unsigned predicted;
    int unsigned results_checked;

    function new();
      clear();
      mismatches = 0;
      predicted = 0;
      results_checked = 0;
    endfunction

    function void clear();
      phase = whp_pkg::PH_RIFF;
      byte_cnt = '0;
      shift = '0;
      tag = '0;
      left = '0;
      file_pos = '0;
      have_fmt = 0;
      have_data = 0;
      fmt_type = '0;
      rate = '0;
      chans = '0;
      smp = whp_pkg::SMP_INT8;
      offset = '0;
      length = '0;
      done = 0;
    endfunction

    // An error result carries nothing but its status.
    function bit close_header(input whp_pkg::whp_status_e st, output wav_info_t r);
      r = '0;
      r.status = st;
      if (st == whp_pkg::ST_OK) begin
        r.sample_rate = rate;
        r.channels = chans;
        r.sample_type = smp;
        r.data_offset = offset;
        r.data_length = length;
      end
      done = 1;
      return 1;
    endfunction

    function void end_of_body();
      byte_cnt = '0;
      phase = (left != 0) ? whp_pkg::PH_SKIP : whp_pkg::PH_CTAG;
    endfunction

    function bit parse_byte(input logic [7:0] b, input bit sof, input bit eof,
                            output wav_info_t r);
      logic [2:0]  need;
      logic [31:0] pos;
      logic [31:0] w;
      logic [15:0] h;
      r = '0;
      if (sof) clear();
      if (done) return 0;
      pos = file_pos;
      file_pos = pos + 32'd1;
      shift = {b, shift[31:8]};
      byte_cnt = byte_cnt + 3'd1;
      case (phase)
        whp_pkg::PH_FSKIP: need = 3'd6;
        whp_pkg::PH_SKIP: need = 3'd1;
        whp_pkg::PH_FTYPE, whp_pkg::PH_FCHAN, whp_pkg::PH_FBITS: need = 3'd2;
        default: need = 3'd4;
      endcase
      if (byte_cnt >= need) begin
        w = shift;
        h = shift[31:16];
        byte_cnt = '0;
        case (phase)
          whp_pkg::PH_RIFF: begin
            if (w != whp_pkg::TagRiff) return close_header(whp_pkg::ST_BAD_TAG, r);
            phase = whp_pkg::PH_RSIZE;
          end
          whp_pkg::PH_RSIZE: phase = whp_pkg::PH_WAVE;
          whp_pkg::PH_WAVE: begin
            if (w != whp_pkg::TagWave) return close_header(whp_pkg::ST_BAD_TAG, r);
            phase = whp_pkg::PH_CTAG;
          end
          whp_pkg::PH_CTAG: begin
            tag = w;
            phase = whp_pkg::PH_CSIZE;
          end
          whp_pkg::PH_CSIZE: begin
            if (tag == whp_pkg::TagFmt) begin
              left = (w > 32'(whp_pkg::FmtFieldBytes)) ?
                     w - 32'(whp_pkg::FmtFieldBytes) : 32'd0;
              phase = whp_pkg::PH_FTYPE;
            end else if (tag == whp_pkg::TagData) begin
              offset = pos + 32'd1;
              length = w;
              have_data = 1;
              if (have_fmt) return close_header(whp_pkg::ST_OK, r);
              left = w;
              end_of_body();
            end else begin
              left = w;
              end_of_body();
            end
          end
          whp_pkg::PH_FTYPE: begin
            fmt_type = h;
            phase = whp_pkg::PH_FCHAN;
          end
          whp_pkg::PH_FCHAN: begin
            chans = h[7:0];
            phase = whp_pkg::PH_FRATE;
          end
          whp_pkg::PH_FRATE: begin
            rate = w;
            phase = whp_pkg::PH_FSKIP;
          end
          whp_pkg::PH_FSKIP: phase = whp_pkg::PH_FBITS;
          whp_pkg::PH_FBITS: begin
            if (h == 16'd8) smp = whp_pkg::SMP_INT8;
            else if (h == 16'd16) smp = whp_pkg::SMP_INT16;
            else if (h == 16'd32 && fmt_type == 16'd1) smp = whp_pkg::SMP_INT32;
            else if (h == 16'd32 && fmt_type == 16'd3) smp = whp_pkg::SMP_FLOAT32;
            else return close_header(whp_pkg::ST_UNSUPPORTED, r);
            have_fmt = 1;
            if (have_data) return close_header(whp_pkg::ST_OK, r);
            end_of_body();
          end
          default: begin
            if (left != 0) left = left - 32'd1;
            if (left == 0) phase = whp_pkg::PH_CTAG;
          end
        endcase
      end
      if (eof) return close_header(whp_pkg::ST_TRUNCATED, r);
      return 0;
    endfunction

    function void note_byte(input logic [7:0] b, input bit sof, input bit eof);
      wav_info_t r;
      if (parse_byte(b, sof, eof, r)) begin
        expected_q.push_back(r);
        predicted++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(input logic [1:0] st, input logic [111:0] d);
      wav_info_t exp;
      results_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result with status %0d arrived while none was owed", st));
        return;
      end
      exp = expected_q.pop_front();
      if (st != exp.status)
        report($sformatf("status got %0d expected %0d", st, exp.status));
      if (d[31:0] != exp.sample_rate)
        report($sformatf("sample_rate got %h expected %h", d[31:0], exp.sample_rate));
      if (d[39:32] != exp.channels)
        report($sformatf("channels got %h expected %h", d[39:32], exp.channels));
      if (d[41:40] != exp.sample_type)
        report($sformatf("sample_type got %0d expected %0d", d[41:40], exp.sample_type));
      if (d[73:42] != exp.data_offset)
        report($sformatf("data_offset got %h expected %h", d[73:42], exp.data_offset));
      if (d[105:74] != exp.data_length)
        report($sformatf("data_length got %h expected %h", d[105:74], exp.data_length));
    endtask

    task check_leftover();
      if (expected_q.size() != 0)
        report($sformatf("%0d results still owed at the end", expected_q.size()));
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i;   // byte_value [7:0]
  logic         s_axis_tuser_i;   // start_of_file [0]
  logic         s_axis_tlast_i;   // end_of_file
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  // sample_rate [31:0], channels [39:32], sample_type [41:40], data_offset [73:42],
  // data_length [105:74], zero padding [111:106]
  logic [111:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;   // status [1:0]

  wav_result_scoreboard sb = new();
  int unsigned cycle_cnt;
  int unsigned stall_cnt;

  wav_header_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Cycle count for the quiet window, and a watchdog on cycles that move nothing.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= StallLimit) begin
      $display("timeout: no request moved for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  // Both sides pause at random, except inside one long quiet window.
  function automatic bit take_break();
    if (cycle_cnt >= QuietFirst && cycle_cnt <= QuietLast) return 0;
    return $urandom_range(99) < 22;
  endfunction

  function automatic void put_le(ref byte_q_t q, input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(ref byte_q_t q, input int n);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A fmt chunk: short, exact or long, with a layout that is mostly supported unless asked for a bad one.
  function automatic void put_fmt(ref byte_q_t q, input bit bad);
    logic [31:0] size;
    logic [15:0] ftype;
    logic [15:0] bits;
    int unsigned sel;
    sel = $urandom_range(99);
    ftype = (sel < 45) ? 16'd1 : (sel < 90) ? 16'd3 : 16'($urandom);
    case ($urandom_range(2))
      0: bits = 16'd8;
      1: bits = 16'd16;
      default: bits = 16'd32;
    endcase
    if (bad) begin
      if ($urandom_range(1)) bits = 16'($urandom);
      else begin
        bits = 16'd32;
        ftype = 16'd2;
      end
    end
    case ($urandom_range(3))
      0, 1: size = whp_pkg::FmtFieldBytes;
      2: size = whp_pkg::FmtFieldBytes + $urandom_range(1, 6);
      default: size = $urandom_range(0, whp_pkg::FmtFieldBytes - 1);
    endcase
    put_le(q, whp_pkg::TagFmt, 4);
    put_le(q, size, 4);
    put_le(q, 32'(ftype), 2);
    put_le(q, $urandom, 2);
    put_le(q, pick_word(), 4);
    put_le(q, $urandom, 4);
    put_le(q, $urandom, 2);
    put_le(q, 32'(bits), 2);
    if (size > whp_pkg::FmtFieldBytes) put_random(q, size - whp_pkg::FmtFieldBytes);
  endfunction

  function automatic void put_junk(ref byte_q_t q, input int count);
    int unsigned n;
    for (int i = 0; i < count; i++) begin
      n = $urandom_range(0, 8);
      put_le(q, $urandom, 4);
      put_le(q, n, 4);
      put_random(q, n);
    end
  endfunction

  // Mostly well-formed files with random content; some cut short, some with a broken
  // tag or an unsupported format, and some plain noise.
  function automatic void compose_file(ref byte_q_t q, output bit eof_last);
    int unsigned kind;
    int unsigned early;
    int unsigned idx;
    int unsigned n;
    q.delete();
    kind = $urandom_range(99);
    eof_last = $urandom_range(1);
    if (kind >= 93) begin
      put_random(q, $urandom_range(1, 24));
      return;
    end
    put_le(q, whp_pkg::TagRiff, 4);
    put_le(q, $urandom, 4);
    put_le(q, whp_pkg::TagWave, 4);
    put_junk(q, $urandom_range(0, 2));
    // Data chunks ahead of fmt have their bodies skipped; the last one counts.
    early = ($urandom_range(99) < 25) ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < early; i++) begin
      n = $urandom_range(0, 10);
      put_le(q, whp_pkg::TagData, 4);
      put_le(q, n, 4);
      put_random(q, n);
    end
    put_fmt(q, kind >= 85);
    if (early == 0) begin
      if ($urandom_range(99) < 15) put_fmt(q, 0);
      put_junk(q, $urandom_range(0, 1));
      put_le(q, whp_pkg::TagData, 4);
      put_le(q, pick_word(), 4);
    end
    put_random(q, $urandom_range(0, 6));
    if (kind >= 75 && kind < 85) begin
      idx = $urandom_range(0, 7);
      if (idx >= 4) idx += 4;
      q[idx] = q[idx] ^ (8'd1 << $urandom_range(7));
    end else if (kind >= 65 && kind < 75) begin
      n = $urandom_range(1, q.size() - 1);
      while (q.size() > n) void'(q.pop_back());
      eof_last = 1;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit sof, input bit eof);
    @(negedge clk_i);
    while (take_break()) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = b;
    s_axis_tuser_i = sof;
    s_axis_tlast_i = eof;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b, sof, eof);
  endtask

  task automatic send_file(input byte_q_t q, input bit sof_first, input bit eof_last);
    for (int i = 0; i < q.size(); i++)
      send_byte(q[i], sof_first && i == 0, eof_last && i == q.size() - 1);
  endtask

  // Receiver: random back-pressure, plus one long hold-off that lets the block fill
  // up and stall its input while the sender keeps offering bytes.
  initial begin
    int unsigned hold_left;
    bit          hold_used;
    hold_left = 0;
    hold_used = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_used && sb.results_checked >= 4) begin
        hold_used = 1;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = !take_break();
      end
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  initial begin
    byte_q_t     q;
    bit          eof_last;
    int unsigned bytes_sent;
    cycle_cnt = 0;
    stall_cnt = 0;
    bytes_sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    s_axis_tlast_i = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a bad RIFF tag straight after reset without a start of file.
    q.delete();
    put_le(q, whp_pkg::TagRiff ^ 32'h0100_0000, 4);
    send_file(q, 0, 0);
    // A one-byte file ends early; the byte after it is dropped even with tlast.
    send_byte(8'hFF, 1, 1);
    send_byte(8'h00, 0, 1);
    // A restart in the middle of a tag, then a bad WAVE tag.
    send_byte(8'h52, 1, 0);
    send_byte(8'h49, 0, 0);
    q.delete();
    put_le(q, whp_pkg::TagRiff, 4);
    put_le(q, 32'hFFFF_FFFF, 4);
    put_le(q, whp_pkg::TagWave ^ 32'h8000_0000, 4);
    send_file(q, 1, 0);

    while (bytes_sent < ByteTarget) begin
      compose_file(q, eof_last);
      send_file(q, $urandom_range(99) < 92, eof_last);
      bytes_sent += q.size();
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.check_leftover();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/whp_pkg.sv
sv/whp_fifo.sv
sv/whp_front.sv
sv/whp_back.sv
sv/wav_header_parser.sv
verif/wav_header_parser_tb.sv
